[hdl/i2cm_pkg.sv]
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  localparam logic [3:0] DATA_BITS  = 4'd8;
  localparam logic [3:0] SLOTS_BYTE = 4'd9;
  localparam logic [3:0] SLOTS_COND = 4'd1;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  // One classified tick, as it travels from the front to the back.
  typedef struct packed {
    logic       is_cmd;
    op_t        op;
    logic [7:0] tx_byte;
    logic       master_nack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_level;
  } result_t;

endpackage

[hdl/i2cm_front.sv]
`timescale 1ns / 1ps

module i2cm_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [i2cm_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           push,
  output i2cm_pkg::item_t                push_item,
  input  logic                           queue_ready
);
  import i2cm_pkg::*;

  logic is_cmd;

  // Kinds outside start..stop carry no command and behave as plain ticks.
  assign is_cmd = (in_tuser >= 3'(OP_START)) && (in_tuser <= 3'(OP_STOP));

  assign in_tready = queue_ready;
  assign push      = in_tvalid && queue_ready;

  always_comb begin
    push_item.is_cmd      = is_cmd;
    push_item.op          = is_cmd ? op_t'(in_tuser) : OP_IDLE;
    push_item.tx_byte     = in_tdata[7:0];
    push_item.master_nack = in_tdata[8];
    push_item.sda_in      = in_tdata[9];
  end

endmodule

[hdl/i2cm_queue.sv]
`timescale 1ns / 1ps

module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cm_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output i2cm_pkg::item_t pop_item
);
  import i2cm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign ready    = count_r != CNT_W'(DEPTH);
  assign valid    = count_r != '0;
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/i2cm_back.sv]
`timescale 1ns / 1ps

module i2cm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [15:0]                     cfg_wdata,
  input  logic                            q_valid,
  input  i2cm_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import i2cm_pkg::*;

  logic [15:0] phase_ticks_r;
  op_t         op_r, op_nxt, op_e;
  logic [1:0]  phase_r, phase_nxt, phase_e;
  logic [15:0] tick_r, tick_nxt, tick_e;
  logic [3:0]  bit_r, bit_nxt, bit_e, bit_inc, slots;
  logic [7:0]  shift_r, shift_nxt, shift_e;
  logic [7:0]  read_r, read_nxt;
  logic        ack_r, ack_nxt;
  logic        nack_r, nack_nxt, nack_e;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        fire, rejected, done, last_tick;
  logic [15:0] plen;
  logic        out_valid_r, out_valid_nxt;
  result_t     res;
  logic [OUT_DATA_W-1:0] out_data_r;

  // One queued tick is executed whenever the output register is free or drains.
  assign fire  = q_valid && (!out_valid_r || out_tready);
  assign q_pop = fire;
  assign plen  = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;

  // A command is taken on an idle tick, and that tick is already its first phase tick.
  always_comb begin
    op_e     = op_r;
    phase_e  = phase_r;
    tick_e   = tick_r;
    bit_e    = bit_r;
    shift_e  = shift_r;
    nack_e   = nack_r;
    rejected = 1'b0;
    if (op_r != OP_IDLE) begin
      rejected = q_item.is_cmd;
    end else if (q_item.is_cmd) begin
      op_e    = q_item.op;
      phase_e = 2'd0;
      tick_e  = 16'd0;
      bit_e   = 4'd0;
      if (q_item.op == OP_WRITE) begin
        shift_e = q_item.tx_byte;
      end else if (q_item.op == OP_READ) begin
        shift_e = 8'd0;
        nack_e  = q_item.master_nack;
      end
    end
  end

  // Next state: phase timing, bit slots and sampling.
  always_comb begin
    op_nxt    = op_e;
    phase_nxt = phase_e;
    tick_nxt  = tick_e;
    bit_nxt   = bit_e;
    shift_nxt = shift_e;
    nack_nxt  = nack_e;
    read_nxt  = read_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    last_tick = ({1'b0, tick_e} + 17'd1) >= {1'b0, plen};
    slots     = (op_e == OP_WRITE || op_e == OP_READ) ? SLOTS_BYTE : SLOTS_COND;
    bit_inc   = bit_e + 4'd1;
    if (op_e != OP_IDLE) begin
      if (phase_e == 2'd1 && last_tick) begin
        if (op_e == OP_WRITE && bit_e == DATA_BITS) begin
          ack_nxt = ~q_item.sda_in;
        end else if (op_e == OP_READ && bit_e < DATA_BITS) begin
          shift_nxt = {shift_e[6:0], q_item.sda_in};
        end
      end
      if (last_tick) begin
        tick_nxt = 16'd0;
        if (phase_e >= 2'd2) begin
          phase_nxt = 2'd0;
          if (bit_inc >= slots) begin
            if (op_e == OP_READ) begin
              read_nxt = shift_e;
            end
            op_nxt  = OP_IDLE;
            bit_nxt = 4'd0;
            done    = 1'b1;
          end else begin
            bit_nxt = bit_inc;
          end
        end else begin
          phase_nxt = phase_e + 2'd1;
        end
      end else begin
        tick_nxt = tick_e + 16'd1;
      end
    end
  end

  // Line drive and the result of this tick. Idle ticks hold the last levels.
  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    if (op_e != OP_IDLE) begin
      case (op_e)
        OP_START: begin
          scl_nxt = phase_e < 2'd2;
          sda_nxt = phase_e == 2'd0;
        end
        OP_STOP: begin
          scl_nxt = phase_e > 2'd0;
          sda_nxt = phase_e == 2'd2;
        end
        default: begin
          scl_nxt = phase_e == 2'd1;
          if (bit_e < DATA_BITS) begin
            sda_nxt = (op_e == OP_WRITE) ? shift_e[3'd7 - bit_e[2:0]] : 1'b1;
          end else begin
            sda_nxt = (op_e == OP_READ) ? nack_e : 1'b1;
          end
        end
      endcase
    end
    res.scl_level   = scl_nxt;
    res.sda_release = sda_nxt;
    res.busy_res    = op_nxt != OP_IDLE;
    res.done_res    = done;
    res.rx_byte     = read_nxt;
    res.ack_seen    = ack_nxt;
    res.rejected    = rejected;
    out_valid_nxt   = fire || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_IDLE;
      phase_r     <= 2'd0;
      tick_r      <= 16'd0;
      bit_r       <= 4'd0;
      shift_r     <= 8'd0;
      read_r      <= 8'd0;
      ack_r       <= 1'b0;
      nack_r      <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        op_r    <= op_nxt;
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        read_r  <= read_nxt;
        ack_r   <= ack_nxt;
        nack_r  <= nack_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= OUT_DATA_W'({2'b00, res});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/i2c_master_byte_engine_unit.sv]
`timescale 1ns / 1ps

// Byte-level I2C master timing engine. Every transfer on the in_ channel is
// one clock tick of bus time: it carries the sampled SDA level and an
// optional command (start, write byte, read byte, stop) in in_tuser. Every
// input transfer yields exactly one output transfer with the SCL and SDA
// drive for that tick, busy, done, the last received byte, the last ACK
// seen and a flag for a command that came in while busy.
// cfg_we/cfg_wdata set the ticks per SCL phase (0 acts as 1); write it only
// while no command is running.
// A tick is written into a small queue when it is accepted; the back end
// pops it and registers its result in the output register. One tick per
// cycle is sustained while out_tready is high.
// When out_tready is low the output register holds its result and the
// queue absorbs up to QUEUE_DEPTH further ticks before in_tready drops.
// After reset the bus is released (SCL and SDA high), the engine is idle
// and the phase length is 10 ticks.
module i2c_master_byte_engine_unit #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: tx_byte[7:0], master_nack[8], sda_in[9], zero [15:10]
  input  logic [i2cm_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind[2:0]
  input  logic [i2cm_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: scl_level[0], sda_release[1], busy_res[2], done_res[3],
  // rx_byte[11:4], ack_seen[12], rejected[13], zero [15:14]
  output logic [i2cm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [15:0]                     cfg_wdata
);
  import i2cm_pkg::*;

  logic  push, queue_ready, q_valid, q_pop;
  item_t push_item, q_item;

  i2cm_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .push        (push),
    .push_item   (push_item),
    .queue_ready (queue_ready)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (queue_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
